>>> rtl/core/nfpa_pkg.sv
package nfpa_pkg;

    localparam int unsigned POOL_BYTES = 65536;
    localparam int unsigned DESC_COUNT = 128;
    localparam int unsigned IDX_W      = $clog2(DESC_COUNT) + 1;
    localparam int unsigned OFF_W      = $clog2(POOL_BYTES);
    localparam int unsigned LEN_W      = OFF_W + 1;
    localparam int unsigned WALK_W     = $clog2(2 * DESC_COUNT + 2) + 1;

    localparam logic [IDX_W-1:0] NIL   = IDX_W'(DESC_COUNT);
    localparam logic [IDX_W-1:0] HEADQ = IDX_W'(DESC_COUNT + 1);

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NODESC  = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFF0;

    // descriptor memory request from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-2:0] waddr;
        logic [OFF_W-1:0] wstart;
        logic [LEN_W-1:0] wlen;
        logic [IDX_W-1:0] wnext;
        logic [IDX_W-2:0] raddr;
    } desc_req_t;

    // descriptor read data
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] next;
    } desc_rd_t;

    function automatic logic [IDX_W-1:0] clean(input logic [IDX_W-1:0] i);
        return (i < IDX_W'(DESC_COUNT)) ? i : NIL;
    endfunction

endpackage

>>> rtl/core/nfpa_desc_mem.sv
// descriptor table: one write port, one registered read port
module nfpa_desc_mem
(
    input  logic                clk,
    input  nfpa_pkg::desc_req_t req,
    output nfpa_pkg::desc_rd_t  rd
);

    nfpa_pkg::desc_rd_t mem [nfpa_pkg::DESC_COUNT];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= '{start: req.wstart, len: req.wlen, next: req.wnext};
        end
        rd <= mem[req.raddr];
    end

endmodule

>>> rtl/core/next_fit_pool_allocator_core.sv
// Next-fit pool allocator. Each request word walks the descriptor lists one
// descriptor per read, wait and check state (read and wait for a query)
// through the descriptor table, which has one write port and a registered
// read port; a spare descriptor is found by a one-per-cycle scan over the
// spare bits. in_ready is low while a request is in progress; the result
// word sits in an output register until taken. pool_base is written by
// cfg_we/cfg_data and only its upper 28 bits are used.
module next_fit_pool_allocator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] amount,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] block_address,
    output logic [16:0] largest_free
);

    localparam int unsigned IW = nfpa_pkg::IDX_W;
    localparam int unsigned OW = nfpa_pkg::OFF_W;
    localparam int unsigned LW = nfpa_pkg::LEN_W;
    localparam int unsigned AW = nfpa_pkg::IDX_W - 1;
    localparam int unsigned DESC_BITS = nfpa_pkg::DESC_COUNT;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_AREAD  = 5'd1;
    localparam logic [4:0] S_AWAIT  = 5'd2;
    localparam logic [4:0] S_ACHK   = 5'd3;
    localparam logic [4:0] S_ASPARE = 5'd4;
    localparam logic [4:0] S_AWRS   = 5'd5;
    localparam logic [4:0] S_AWRP   = 5'd6;
    localparam logic [4:0] S_AWRQ   = 5'd7;
    localparam logic [4:0] S_FREAD  = 5'd8;
    localparam logic [4:0] S_FWAIT  = 5'd9;
    localparam logic [4:0] S_FCHK   = 5'd10;
    localparam logic [4:0] S_FUNL   = 5'd11;
    localparam logic [4:0] S_IREAD  = 5'd12;
    localparam logic [4:0] S_IWAIT  = 5'd13;
    localparam logic [4:0] S_ICHK   = 5'd14;
    localparam logic [4:0] S_IMRD   = 5'd15;
    localparam logic [4:0] S_IMW    = 5'd16;
    localparam logic [4:0] S_IPW    = 5'd17;
    localparam logic [4:0] S_QREAD  = 5'd18;
    localparam logic [4:0] S_QWAIT  = 5'd19;
    localparam logic [4:0] S_DONE   = 5'd20;
    localparam logic [4:0] S_FQW    = 5'd21;

    logic [4:0]    state_reg, state_next;
    logic [31:0]   base_reg;
    logic [IW-1:0] free_head_reg, free_head_next;
    logic [IW-1:0] used_head_reg, used_head_next;
    logic [IW-1:0] rover_reg, rover_next;
    logic [DESC_BITS-1:0] spare_reg, spare_next;

    // walk registers
    logic [IW-1:0] q_reg, q_next, p_reg, p_next, m_reg, m_next, s_reg, s_next;
    logic [nfpa_pkg::WALK_W-1:0] n_reg, n_next;
    logic [LW-1:0] need_reg, need_next;
    logic [31:0]   off_reg, off_next;
    logic [LW-1:0] mx_reg, mx_next;
    // saved copies of descriptors
    nfpa_pkg::desc_rd_t pd_reg, pd_next, md_reg, md_next, qd_reg, qd_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic          qneed_reg, qneed_next;

    logic [1:0]    st_reg, st_next;
    logic [31:0]   addr_reg, addr_next;
    logic [16:0]   lf_reg, lf_next;
    logic          ov_reg, ov_next;

    nfpa_pkg::desc_req_t req;
    nfpa_pkg::desc_rd_t  rd;

    nfpa_desc_mem u_mem (.clk(clk), .req(req), .rd(rd));

    assign in_ready      = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign block_address = addr_reg;
    assign largest_free  = lf_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data & nfpa_pkg::ALIGN_MASK;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            used_head_reg <= nfpa_pkg::NIL;
            rover_reg     <= '0;
            spare_reg     <= {{(DESC_BITS-1){1'b1}}, 1'b0};
            ov_reg        <= 1'b0;
            qneed_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            rover_reg     <= rover_next;
            spare_reg     <= spare_next;
            ov_reg        <= ov_next;
            qneed_reg     <= qneed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;  p_reg <= p_next;  m_reg <= m_next;  s_reg <= s_next;
        n_reg <= n_next;  need_reg <= need_next;  off_reg <= off_next;
        mx_reg <= mx_next;
        pd_reg <= pd_next;  md_reg <= md_next;  qd_reg <= qd_next;
        scan_reg <= scan_next;
        st_reg <= st_next;  addr_reg <= addr_next;  lf_reg <= lf_next;
    end

    // descriptor 0 reads as its reset value until first written
    logic d0_written_reg, d0_written_next;
    nfpa_pkg::desc_rd_t rdv;
    logic [AW-1:0] raddr_q_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_written_reg <= 1'b0;
        end
        else
        begin
            d0_written_reg <= d0_written_next;
        end
    end
    always_ff @(posedge clk)
    begin
        raddr_q_reg <= req.raddr;
    end
    assign d0_written_next = d0_written_reg || (req.we && req.waddr == '0);
    always_comb
    begin
        rdv = rd;
        if (raddr_q_reg == '0 && !d0_written_reg)
        begin
            rdv = '{start: '0, len: LW'(nfpa_pkg::POOL_BYTES), next: nfpa_pkg::NIL};
        end
    end

    logic [LW-1:0] rnd;
    logic [31:0]   amt_even;
    logic [AW-1:0] p_a, m_a, q_a;
    assign p_a = p_reg[AW-1:0];
    assign m_a = m_reg[AW-1:0];
    assign q_a = q_reg[AW-1:0];
    assign amt_even = amount + 32'(amount[0]) + 32'd15;
    assign rnd = LW'(amt_even & nfpa_pkg::ALIGN_MASK);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        free_head_next = free_head_reg;  used_head_next = used_head_reg;
        rover_next = rover_reg;  spare_next = spare_reg;
        q_next = q_reg;  p_next = p_reg;  m_next = m_reg;  s_next = s_reg;
        n_next = n_reg;  need_next = need_reg;  off_next = off_reg;
        mx_next = mx_reg;
        pd_next = pd_reg;  md_next = md_reg;  qd_next = qd_reg;
        scan_next = scan_reg;  qneed_next = qneed_reg;
        st_next = st_reg;  addr_next = addr_reg;  lf_next = lf_reg;
        ov_next = ov_reg && !out_ready;
        req = '{we: 1'b0, waddr: '0, wstart: '0, wlen: '0, wnext: '0, raddr: '0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    st_next = nfpa_pkg::ST_NOFIT;
                    addr_next = '0;
                    lf_next = '0;
                    n_next = '0;
                    mx_next = '0;
                    state_next = S_DONE;
                    if (action == nfpa_pkg::ACT_ALLOC)
                    begin
                        need_next = rnd;
                        if (amount != '0 && amount <= 32'(nfpa_pkg::POOL_BYTES)
                            && nfpa_pkg::clean(rover_reg) != nfpa_pkg::NIL)
                        begin
                            q_next = rover_reg;
                            // fetch rover to learn its link
                            p_next = rover_reg;
                            qneed_next = 1'b1;
                            state_next = S_AREAD;
                        end
                    end
                    else if (action == nfpa_pkg::ACT_FREE)
                    begin
                        off_next = address - base_reg;
                        q_next = nfpa_pkg::NIL;
                        p_next = nfpa_pkg::clean(used_head_reg);
                        state_next = S_FREAD;
                    end
                    else if (action == nfpa_pkg::ACT_QUERY)
                    begin
                        st_next = nfpa_pkg::ST_OK;
                        p_next = nfpa_pkg::clean(free_head_reg);
                        state_next = (nfpa_pkg::clean(rover_reg) == nfpa_pkg::NIL)
                                     ? S_DONE : S_QREAD;
                    end
                end
            end

            // allocate walk: issue read of p
            S_AREAD:
            begin
                if (!qneed_reg && p_reg == nfpa_pkg::NIL)
                begin
                    q_next = nfpa_pkg::HEADQ;
                    p_next = nfpa_pkg::clean(free_head_reg);
                    if (nfpa_pkg::clean(free_head_reg) == nfpa_pkg::NIL)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    req.raddr = p_a;
                    state_next = S_AWAIT;
                end
            end

            S_AWAIT:
            begin
                if (qneed_reg)
                begin
                    // rover descriptor: keep it, start at its link
                    qd_next = rdv;
                    qneed_next = 1'b0;
                    p_next = nfpa_pkg::clean(rdv.next);
                    state_next = S_AREAD;
                end
                else
                begin
                    pd_next = rdv;
                    state_next = S_ACHK;
                end
            end

            S_ACHK:
            begin
                if (pd_reg.len >= need_reg)
                begin
                    if (pd_reg.len == need_reg)
                    begin
                        s_next = nfpa_pkg::clean(pd_reg.next);
                        state_next = S_AWRP;
                    end
                    else
                    begin
                        scan_next = '0;
                        state_next = S_ASPARE;
                    end
                end
                else if (n_reg == nfpa_pkg::WALK_W'(2 * nfpa_pkg::DESC_COUNT + 1)
                         || p_reg == rover_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                    q_next = p_reg;
                    qd_next = pd_reg;
                    p_next = nfpa_pkg::clean(pd_reg.next);
                    state_next = S_AREAD;
                end
            end

            // one spare bit per cycle
            S_ASPARE:
            begin
                if (spare_reg[scan_reg])
                begin
                    spare_next[scan_reg] = 1'b0;
                    s_next = {1'b0, scan_reg};
                    state_next = S_AWRS;
                end
                else if (scan_reg == AW'(nfpa_pkg::DESC_COUNT - 1))
                begin
                    st_next = nfpa_pkg::ST_NODESC;
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_AWRS:
            begin
                req.we = 1'b1;
                req.waddr = s_reg[AW-1:0];
                req.wstart = pd_reg.start + OW'(need_reg);
                req.wlen = pd_reg.len - need_reg;
                req.wnext = nfpa_pkg::clean(pd_reg.next);
                pd_next.len = need_reg;
                state_next = S_AWRP;
            end

            // p joins the allocated list; s is the successor to link
            S_AWRP:
            begin
                req.we = 1'b1;
                req.waddr = p_a;
                req.wstart = pd_reg.start;
                req.wlen = pd_reg.len;
                req.wnext = used_head_reg;
                used_head_next = p_reg;
                st_next = nfpa_pkg::ST_OK;
                addr_next = base_reg + 32'(pd_reg.start);
                if (q_reg == nfpa_pkg::HEADQ)
                begin
                    free_head_next = s_reg;
                    rover_next = s_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rover_next = q_reg;
                    state_next = S_AWRQ;
                end
            end

            S_AWRQ:
            begin
                req.we = 1'b1;
                req.waddr = q_a;
                req.wstart = qd_reg.start;
                req.wlen = qd_reg.len;
                req.wnext = s_reg;
                state_next = S_DONE;
            end

            // free: search allocated list
            S_FREAD:
            begin
                if (p_reg == nfpa_pkg::NIL || n_reg == nfpa_pkg::WALK_W'(nfpa_pkg::DESC_COUNT))
                begin
                    st_next = nfpa_pkg::ST_BADADDR;
                    state_next = S_DONE;
                end
                else
                begin
                    req.raddr = p_a;
                    state_next = S_FWAIT;
                end
            end

            S_FWAIT:
            begin
                pd_next = rdv;
                state_next = S_FCHK;
            end

            S_FCHK:
            begin
                if (32'(pd_reg.start) == off_reg)
                begin
                    m_next = p_reg;
                    md_next = pd_reg;
                    state_next = S_FUNL;
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                    q_next = p_reg;
                    qd_next = pd_reg;
                    p_next = nfpa_pkg::clean(pd_reg.next);
                    state_next = S_FREAD;
                end
            end

            // unlink m from allocated list
            S_FUNL:
            begin
                if (q_reg == nfpa_pkg::NIL)
                begin
                    used_head_next = nfpa_pkg::clean(md_reg.next);
                end
                else
                begin
                    req.we = 1'b1;
                    req.waddr = q_a;
                    req.wstart = qd_reg.start;
                    req.wlen = qd_reg.len;
                    req.wnext = nfpa_pkg::clean(md_reg.next);
                end
                n_next = '0;
                q_next = nfpa_pkg::NIL;
                p_next = nfpa_pkg::clean(free_head_reg);
                state_next = S_FQW;
            end

            S_FQW:
            begin
                state_next = S_IREAD;
            end

            // insert: find first free block at or above m
            S_IREAD:
            begin
                if (p_reg == nfpa_pkg::NIL || n_reg == nfpa_pkg::WALK_W'(nfpa_pkg::DESC_COUNT))
                begin
                    state_next = S_IMW;
                    if (nfpa_pkg::clean(rover_reg) == nfpa_pkg::NIL)
                    begin
                        rover_next = m_reg;
                    end
                    if (q_reg == nfpa_pkg::NIL)
                    begin
                        free_head_next = m_reg;
                    end
                end
                else
                begin
                    req.raddr = p_a;
                    state_next = S_IWAIT;
                end
            end

            S_IWAIT:
            begin
                pd_next = rdv;
                state_next = S_ICHK;
            end

            S_ICHK:
            begin
                if (md_reg.start <= pd_reg.start)
                begin
                    state_next = S_IMRD;
                    if (nfpa_pkg::clean(rover_reg) == nfpa_pkg::NIL)
                    begin
                        rover_next = m_reg;
                    end
                    if (q_reg == nfpa_pkg::NIL)
                    begin
                        free_head_next = m_reg;
                    end
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                    q_next = p_reg;
                    qd_next = pd_reg;
                    p_next = nfpa_pkg::clean(pd_reg.next);
                    state_next = S_IREAD;
                end
            end

            // merge with successor p when adjacent
            S_IMRD:
            begin
                md_next.next = p_reg;
                if (LW'(md_reg.start) + md_reg.len == LW'(pd_reg.start))
                begin
                    md_next.len = md_reg.len + pd_reg.len;
                    md_next.next = nfpa_pkg::clean(pd_reg.next);
                    if (rover_next == p_reg)
                    begin
                        rover_next = m_reg;
                    end
                    spare_next[p_a] = 1'b1;
                end
                state_next = S_IPW;
            end

            // write m, or merge m into predecessor
            S_IMW:
            begin
                md_next.next = nfpa_pkg::NIL;
                state_next = S_IPW;
            end

            S_IPW:
            begin
                req.we = 1'b1;
                if (q_reg != nfpa_pkg::NIL
                    && LW'(qd_reg.start) + qd_reg.len == LW'(md_reg.start))
                begin
                    req.waddr = q_a;
                    req.wstart = qd_reg.start;
                    req.wlen = qd_reg.len + md_reg.len;
                    req.wnext = nfpa_pkg::clean(md_reg.next);
                    if (rover_reg == m_reg)
                    begin
                        rover_next = q_reg;
                    end
                    spare_next[m_a] = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    req.waddr = m_a;
                    req.wstart = md_reg.start;
                    req.wlen = md_reg.len;
                    req.wnext = md_reg.next;
                    if (q_reg != nfpa_pkg::NIL)
                    begin
                        // relink predecessor to m next cycle
                        md_next.next = m_reg;
                        m_next = q_reg;
                        md_next.start = qd_reg.start;
                        md_next.len = qd_reg.len;
                        q_next = nfpa_pkg::NIL;
                        state_next = S_IPW;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                st_next = nfpa_pkg::ST_OK;
            end

            // query walk
            S_QREAD:
            begin
                if (p_reg == nfpa_pkg::NIL || n_reg == nfpa_pkg::WALK_W'(nfpa_pkg::DESC_COUNT))
                begin
                    lf_next = (mx_reg < LW'(15)) ? '0
                              : 17'((mx_reg - LW'(15)) & LW'(nfpa_pkg::ALIGN_MASK));
                    state_next = S_DONE;
                end
                else
                begin
                    req.raddr = p_a;
                    state_next = S_QWAIT;
                end
            end

            S_QWAIT:
            begin
                if (rdv.len > mx_reg)
                begin
                    mx_next = rdv.len;
                end
                n_next = n_reg + 1'b1;
                p_next = nfpa_pkg::clean(rdv.next);
                state_next = S_QREAD;
            end

            S_DONE:
            begin
                if (st_reg != nfpa_pkg::ST_OK)
                begin
                    addr_next = '0;
                end
                ov_next = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid) else $error("no result after done");
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != nfpa_pkg::ST_OK) |-> (block_address == '0))
        else $error("address on failure");
    a_desc0_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(d0_written_reg) |-> $past(req.we)) else $error("desc0 flag");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned ND        = nfpa_pkg::DESC_COUNT;
    localparam int unsigned STALL_LIM = 20000;
    localparam logic [1:0]  ACT_UNKNOWN = 2'd3;

    // one result word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
        logic [16:0] largest_free;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] amount;
    logic [31:0] address;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [16:0] largest_free;

    next_fit_pool_allocator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .amount        (amount),
        .address       (address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_address (block_address),
        .largest_free  (largest_free)
    );

    // shadow pool state
    int unsigned   sh_base;
    int unsigned   sh_start  [ND];
    int unsigned   sh_len    [ND];
    int unsigned   sh_next   [ND];
    bit            sh_spare  [ND];
    int unsigned   sh_free_head;
    int unsigned   sh_used_head;
    int unsigned   sh_rover;

    alloc_result_t pending_results[$];
    int unsigned   live_blocks[$];
    int            mismatch_count;
    int            result_count;
    int            word_count;
    int            ok_allocs;
    int            ok_frees;
    int            idle_cycles;
    bit            stalling_allowed;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned norm_idx(int unsigned i);
        return (i < ND) ? i : ND;
    endfunction

    function automatic void link_into(int unsigned q, int unsigned v);
        if (q == ND + 1) sh_free_head = v;
        else if (q < ND) sh_next[q] = v;
    endfunction

    function automatic void shadow_reset();
        sh_base = 0;
        for (int i = 0; i < ND; i++)
        begin
            sh_start[i] = 0;
            sh_len[i]   = 0;
            sh_next[i]  = ND;
            sh_spare[i] = 1'b1;
        end
        sh_len[0]    = nfpa_pkg::POOL_BYTES;
        sh_spare[0]  = 1'b0;
        sh_free_head = 0;
        sh_used_head = ND;
        sh_rover     = 0;
    endfunction

    function automatic int unsigned claim_spare();
        for (int i = 0; i < ND; i++)
            if (sh_spare[i])
            begin
                sh_spare[i] = 1'b0;
                return i;
            end
        return ND;
    endfunction

    // next-fit search from the rover
    function automatic logic [1:0] carve_block(int unsigned need, output int unsigned addr);
        int unsigned q, p, s;
        addr = 0;
        q = norm_idx(sh_rover);
        if (q == ND) return nfpa_pkg::ST_NOFIT;
        p = norm_idx(sh_next[q]);
        for (int n = 0; n < 2 * ND + 2; n++)
        begin
            if (p == ND)
            begin
                q = ND + 1;
                p = norm_idx(sh_free_head);
                if (p == ND) return nfpa_pkg::ST_NOFIT;
            end
            if (sh_len[p] >= need)
            begin
                if (sh_len[p] == need)
                    link_into(q, norm_idx(sh_next[p]));
                else
                begin
                    s = claim_spare();
                    if (s == ND) return nfpa_pkg::ST_NODESC;
                    sh_len[s]   = sh_len[p] - need;
                    sh_start[s] = sh_start[p] + need;
                    sh_next[s]  = norm_idx(sh_next[p]);
                    sh_len[p]   = need;
                    link_into(q, s);
                end
                sh_next[p]   = sh_used_head;
                sh_used_head = p;
                sh_rover     = (q == ND + 1) ? sh_free_head : q;
                addr = (sh_base & nfpa_pkg::ALIGN_MASK) + sh_start[p];
                return nfpa_pkg::ST_OK;
            end
            q = p;
            p = norm_idx(sh_next[p]);
            if (q == sh_rover) break;
        end
        return nfpa_pkg::ST_NOFIT;
    endfunction

    // address-ordered insert with merging on both sides
    function automatic void return_to_free(int unsigned m);
        int unsigned prv, p, n;
        prv = ND;
        p = norm_idx(sh_free_head);
        n = 0;
        while (p != ND && n < ND)
        begin
            if (sh_start[m] <= sh_start[p]) break;
            prv = p;
            p = norm_idx(sh_next[p]);
            n++;
        end
        sh_next[m] = p;
        if (prv == ND) sh_free_head = m; else sh_next[prv] = m;
        if (norm_idx(sh_rover) == ND) sh_rover = m;
        if (p != ND && sh_start[m] + sh_len[m] == sh_start[p])
        begin
            sh_len[m] += sh_len[p];
            sh_next[m] = norm_idx(sh_next[p]);
            if (sh_rover == p) sh_rover = m;
            sh_spare[p] = 1'b1;
        end
        if (prv != ND && sh_start[prv] + sh_len[prv] == sh_start[m])
        begin
            sh_len[prv] += sh_len[m];
            sh_next[prv] = norm_idx(sh_next[m]);
            if (sh_rover == m) sh_rover = prv;
            sh_spare[m] = 1'b1;
        end
    endfunction

    function automatic logic [1:0] release_block(int unsigned addr);
        int unsigned off, prv, p, n;
        off = addr - (sh_base & nfpa_pkg::ALIGN_MASK);
        prv = ND;
        p = norm_idx(sh_used_head);
        n = 0;
        while (p != ND && n < ND)
        begin
            if (sh_start[p] == off) break;
            prv = p;
            p = norm_idx(sh_next[p]);
            n++;
        end
        if (p == ND || n >= ND) return nfpa_pkg::ST_BADADDR;
        if (prv == ND) sh_used_head = norm_idx(sh_next[p]);
        else sh_next[prv] = norm_idx(sh_next[p]);
        return_to_free(p);
        return nfpa_pkg::ST_OK;
    endfunction

    function automatic int unsigned largest_hole();
        int unsigned p, n, mx;
        p = norm_idx(sh_free_head);
        n = 0;
        mx = 0;
        if (norm_idx(sh_rover) == ND) return 0;
        while (p != ND && n < ND)
        begin
            if (sh_len[p] > mx) mx = sh_len[p];
            p = norm_idx(sh_next[p]);
            n++;
        end
        if (mx < 15) return 0;
        return (mx - 15) & nfpa_pkg::ALIGN_MASK;
    endfunction

    // expected result of one request word
    function automatic alloc_result_t predict_request(logic [1:0] act, int unsigned amt,
                                                      int unsigned addr);
        alloc_result_t r;
        int unsigned need, got;
        r = '0;
        r.status = nfpa_pkg::ST_NOFIT;
        if (act == nfpa_pkg::ACT_ALLOC)
        begin
            if (amt != 0 && amt <= nfpa_pkg::POOL_BYTES)
            begin
                need = amt;
                if (need & 1) need++;
                need = (need + 15) & nfpa_pkg::ALIGN_MASK;
                r.status = carve_block(need, got);
                if (r.status == nfpa_pkg::ST_OK)
                begin
                    r.block_address = got;
                    live_blocks.push_back(got);
                    ok_allocs++;
                end
            end
        end
        else if (act == nfpa_pkg::ACT_FREE)
        begin
            r.status = release_block(addr);
            if (r.status == nfpa_pkg::ST_OK)
            begin
                foreach (live_blocks[i])
                    if (live_blocks[i] == addr)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
                ok_frees++;
            end
        end
        else if (act == nfpa_pkg::ACT_QUERY)
        begin
            r.status = nfpa_pkg::ST_OK;
            r.largest_free = 17'(largest_hole());
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // send one request word; valid stays up when the next word follows at once
    task automatic send_word(logic [1:0] act, logic [31:0] amt, logic [31:0] addr);
        int unsigned gap;
        gap = stalling_allowed ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        amount   <= amt;
        address  <= addr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(predict_request(act, amt, addr));
        word_count++;
    endtask

    // result checker and output stalls
    initial
    begin
        alloc_result_t exp_r;
        int unsigned stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: status=%0d", status);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (status !== exp_r.status || block_address !== exp_r.block_address
                        || largest_free !== exp_r.largest_free)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp st=%0d addr=%h lf=%0d",
                                     exp_r.status, exp_r.block_address,
                                     exp_r.largest_free,
                                     "  got st=%0d addr=%h lf=%0d",
                                     status, block_address, largest_free);
                    end
                end
            end
            stall = stalling_allowed ? pick_gap() : 0;
            out_ready <= (stall == 0);
        end
    end

    // watchdog on accept activity
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIM)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4 * ND + 40) @(posedge clk);
    endtask

    task automatic write_base(logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_base = value;
    endtask

    function automatic logic [31:0] some_live();
        if (live_blocks.size() == 0) return (sh_base & nfpa_pkg::ALIGN_MASK);
        return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    endfunction

    task automatic test_directed();
        send_word(nfpa_pkg::ACT_QUERY, 0, 0);
        send_word(nfpa_pkg::ACT_ALLOC, 0, 0);
        send_word(nfpa_pkg::ACT_ALLOC, nfpa_pkg::POOL_BYTES + 1, 0);
        send_word(nfpa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 0);
        send_word(ACT_UNKNOWN, 32'h10, 0);
        send_word(nfpa_pkg::ACT_FREE, 0, 32'h1234_5678);
        send_word(nfpa_pkg::ACT_ALLOC, 1, 0);
        send_word(nfpa_pkg::ACT_ALLOC, 17, 0);
        send_word(nfpa_pkg::ACT_ALLOC, 31, 0);
        send_word(nfpa_pkg::ACT_QUERY, 0, 0);
        send_word(nfpa_pkg::ACT_FREE, 0, sh_base & nfpa_pkg::ALIGN_MASK);
        send_word(nfpa_pkg::ACT_FREE, 0, sh_base & nfpa_pkg::ALIGN_MASK);
        send_word(nfpa_pkg::ACT_FREE, 0, (sh_base & nfpa_pkg::ALIGN_MASK) + 32'h30);
        send_word(nfpa_pkg::ACT_FREE, 0, (sh_base & nfpa_pkg::ALIGN_MASK) + 32'h10);
        send_word(nfpa_pkg::ACT_ALLOC, nfpa_pkg::POOL_BYTES, 0);
        send_word(nfpa_pkg::ACT_QUERY, 0, 0);
        send_word(nfpa_pkg::ACT_ALLOC, 16, 0);
        send_word(nfpa_pkg::ACT_FREE, 0, sh_base & nfpa_pkg::ALIGN_MASK);
        send_word(nfpa_pkg::ACT_QUERY, 0, 0);
    endtask

    // drain all descriptors to hit the no-spare case
    task automatic test_desc_exhaust();
        for (int i = 0; i < ND + 4; i++) send_word(nfpa_pkg::ACT_ALLOC, 16, 0);
        send_word(nfpa_pkg::ACT_QUERY, 0, 0);
        send_word(nfpa_pkg::ACT_ALLOC, 5000, 0);
        while (live_blocks.size() != 0) send_word(nfpa_pkg::ACT_FREE, 0, some_live());
        send_word(nfpa_pkg::ACT_QUERY, 0, 0);
    endtask

    task automatic test_random(int unsigned n_words);
        int unsigned pick;
        for (int unsigned i = 0; i < n_words; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_word(nfpa_pkg::ACT_ALLOC, ($urandom_range(0, 15) == 0) ? $urandom()
                          : $urandom_range(1, ($urandom_range(0, 9) == 0) ? 8192 : 600),
                          $urandom());
            else if (pick < 80)
                send_word(nfpa_pkg::ACT_FREE, $urandom(), some_live());
            else if (pick < 88)
                send_word(nfpa_pkg::ACT_FREE, $urandom(),
                          ($urandom_range(0, 1) == 0) ? $urandom() : some_live() + 32'h8);
            else if (pick < 96)
                send_word(nfpa_pkg::ACT_QUERY, $urandom(), $urandom());
            else
                send_word(ACT_UNKNOWN, $urandom(), $urandom());
        end
    endtask

    initial
    begin
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action   <= '0;
        amount   <= '0;
        address  <= '0;
        rst_n    <= 1'b0;
        mismatch_count = 0;
        result_count = 0;
        word_count = 0;
        ok_allocs = 0;
        ok_frees = 0;
        stalling_allowed = 1'b0;
        shadow_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();
        write_base(32'hFFFF_FFFF);
        stalling_allowed = 1'b1;
        test_directed();
        test_desc_exhaust();
        wait_drained();
        write_base(32'h1234_567F);
        test_random(400);
        wait_drained();
        write_base(32'h0);
        stalling_allowed = 1'b0;
        test_random(100);
        stalling_allowed = 1'b1;
        wait_drained();
        write_base($urandom());
        test_random(450);
        wait_drained();

        $display("covered %0d request words, %0d allocations and %0d frees succeeded",
                 word_count, ok_allocs, ok_frees);
        $display("checked %0d result words, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/nfpa_pkg.sv
rtl/core/nfpa_desc_mem.sv
rtl/core/next_fit_pool_allocator_core.sv
tb/sv/tb.sv
